// ===== hw/rtl/cstr_pkg.sv =====
// cstr_pkg: shared types and constants for the contrast stretch unit
// no dependencies; imported by every cstr module and the top level
`timescale 1ns / 1ps
`default_nettype none

package cstr_pkg;

    localparam int PIX_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    // command codes carried in bit 0 of s_tuser
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_STRETCH = 1'b1;

    // one stretch job with the levels seen when it was accepted
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] low_level;
        logic [PIX_W-1:0] high_level;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cstr_front.sv =====
// cstr_front: accepts input transfers, tracks min and max on measure items
// and hands stretch jobs to the queue; depends on cstr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cstr_front
    import cstr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,
    input  wire logic [1:0]       s_tuser,
    input  wire q_stat_t          q_stat,
    output logic                  q_push,
    output job_t                  q_job
);

    logic [PIX_W-1:0] low_reg, low_next;
    logic [PIX_W-1:0] high_reg, high_next;
    logic             accept;
    logic             cmd;
    logic             first;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser[0];
    assign first    = s_tuser[1];

    assign q_push           = accept && (cmd == CMD_STRETCH);
    assign q_job.pixel      = s_tdata;
    assign q_job.low_level  = low_reg;
    assign q_job.high_level = high_reg;

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (accept && (cmd == CMD_MEASURE)) begin
            if (first) begin
                low_next  = s_tdata;
                high_next = s_tdata;
            end else begin
                if (s_tdata < low_reg) begin
                    low_next = s_tdata;
                end
                if (s_tdata > high_reg) begin
                    high_next = s_tdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cstr_queue.sv =====
// cstr_queue: short first-in first-out queue of stretch jobs
// between front and back; depends on cstr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cstr_queue
    import cstr_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output q_stat_t   stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CntW'(Depth));
    assign stat.empty = (count_reg == '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cstr_back.sv =====
// cstr_back: takes stretch jobs from the queue, scales them with a
// radix-2 restoring divider and holds the result for the master side; depends on cstr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cstr_back
    import cstr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire q_stat_t           q_stat,
    input  wire job_t              head_job,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [PIX_W-1:0]       m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    localparam int NumW = 2 * PIX_W;
    localparam int DvdW = NumW + 1;
    localparam int DvsW = PIX_W + 1;
    localparam int CntW = $clog2(PIX_W);

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [DvdW-1:0]  rem_reg, rem_next;
    logic [NumW-1:0]  dsh_reg, dsh_next;
    logic [PIX_W-1:0] quo_reg, quo_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_data_reg, out_data_next;

    logic [PIX_W-1:0] dif;
    logic [PIX_W-1:0] rng;
    logic [NumW-1:0]  num;
    logic [DvdW-1:0]  dvd;
    logic [DvsW-1:0]  dvs;
    logic [DvdW-1:0]  lim;
    logic             fits;
    logic             out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;

    // (2*(p-low)*255 + range) / (2*range)
    assign dif = job_reg.pixel - job_reg.low_level;
    assign rng = job_reg.high_level - job_reg.low_level;
    assign num = {dif, PIX_W'(0)} - {PIX_W'(0), dif};
    assign dvd = {num, 1'b0} + {DvsW'(0), rng};
    assign dvs = {rng, 1'b0};
    assign lim = {dvs, PIX_W'(0)};
    assign fits = (rem_reg >= {1'b0, dsh_reg});

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    job_next   = head_job;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                rem_next = dvd;
                dsh_next = {dvs, (PIX_W - 1)'(0)};
                cnt_next = CntW'(PIX_W - 1);
                quo_next = '0;
                if (job_reg.low_level == job_reg.high_level) begin
                    quo_next   = job_reg.pixel;
                    state_next = S_DONE;
                end else if (job_reg.pixel <= job_reg.low_level) begin
                    quo_next   = '0;
                    state_next = S_DONE;
                end else if (dvd >= lim) begin
                    quo_next   = '1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - {1'b0, dsh_reg};
                end
                quo_next = {quo_reg[PIX_W-2:0], fits};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = quo_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/contrast_stretch_unit.sv =====
// contrast_stretch_unit: top level of the 8-bit linear contrast stretch
// depends on cstr_pkg, cstr_front, cstr_queue and cstr_back
//
// channel   dir   tdata           tuser
// s_        in    pixel[7:0]      command[0], first[1]
// m_        out   stretched[7:0]  -
//
// a measure transfer updates the registered min and max when it is accepted
// a stretch transfer passes through the back end as pop, prepare, eight
// divider steps and hand-off; flat, below-minimum and saturating cases skip
// the radix-2 divider steps in cstr_back; hand-off waits until the last result is taken
// reset clears both levels to 0, empties the queue and drops m_tvalid
// s_tready falls only while the job queue is full
`timescale 1ns / 1ps
`default_nettype none

module contrast_stretch_unit
    import cstr_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,   // pixel
    input  wire logic [1:0]       s_tuser,   // command, first
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [PIX_W-1:0]      m_tdata    // stretched_pixel
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    job_t    push_job;
    job_t    head_job;

    cstr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    cstr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    cstr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_job (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    a_queue_stat_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_push_grows_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("queue empty after a transfer was pushed");

endmodule

`default_nettype wire
